// ----- rtl/core/cbm_pkg.sv -----
// Shared constants for the checked byte memory: access codes, fault codes and bank layout.
package cbm_pkg;

    localparam int DATA_W    = 32;
    localparam int ACTION_W  = 3;
    localparam int FAULT_W   = 2;
    localparam int NUM_BANKS = 4;
    localparam int BYTE_W    = 8;

    localparam logic [ACTION_W-1:0] ACT_FETCH = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RD8   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RD32  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WR8   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WR32  = 3'd4;

    localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_BELOW = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_TOP   = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ----- rtl/core/checked_byte_memory_with_counters_top.sv -----
// Bounds-checked little-endian byte memory with fetch, load and store counters.
//
//  Channel  | Direction | Handshake                | Word carried
//  ---------+-----------+--------------------------+-------------------------------------------
//  s_       | in        | s_valid / s_ready        | action, address, write data
//  m_       | out       | m_valid / m_ready        | read data, fault code, three counter values
//  cfg_     | in        | cfg_valid / cfg_ready    | base address (always ready)
//
// An access word is captured at its accepting edge and then passes through ST_CHECK
// for the base subtract and bounds compare, ST_ACCESS for the bank access and ST_DONE
// to assemble the read data. The input reopens at the edge that loads the result, so
// one word is in flight at a time. After reset the four byte banks are swept to zero,
// one row per cycle, over (MEM_BYTES + 3) / 4 rows (16384 at the default size);
// s_ready stays low meanwhile.
// A result waiting on m_ready does not block acceptance of the next word; only the
// final assembly step holds until the output register is free.
module checked_byte_memory_with_counters_top #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cbm_pkg::DATA_W-1:0]      cfg_base_address,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cbm_pkg::ACTION_W-1:0]    s_action,
    input  logic [cbm_pkg::DATA_W-1:0]      s_address,
    input  logic [cbm_pkg::DATA_W-1:0]      s_write_data,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cbm_pkg::DATA_W-1:0]      m_read_data,
    output logic [cbm_pkg::FAULT_W-1:0]     m_fault_code,
    output logic [cbm_pkg::DATA_W-1:0]      m_fetch_count,
    output logic [cbm_pkg::DATA_W-1:0]      m_load_count,
    output logic [cbm_pkg::DATA_W-1:0]      m_store_count
);
    import cbm_pkg::*;

    // The store is split into four byte-wide banks so that an unaligned word can
    // touch all four of its bytes in the same cycle. Byte offset o lives in bank o % 4,
    // row o / 4.
    localparam int BANK_DEPTH = (MEM_BYTES + NUM_BANKS - 1) / NUM_BANKS;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int OFF_W      = ROW_W + 2;
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(BANK_DEPTH - 1);
    // Highest legal offset for a byte and for a word access.
    localparam logic [DATA_W-1:0] LIMIT_BYTE = DATA_W'(MEM_BYTES - 1);
    localparam logic [DATA_W-1:0] LIMIT_WORD = DATA_W'(MEM_BYTES - NUM_BANKS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_ACCESS,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [ROW_W-1:0]       clr_row_reg, clr_row_next;
    logic [DATA_W-1:0]      base_reg, base_next;

    logic [ACTION_W-1:0]    act_reg, act_next;
    logic [DATA_W-1:0]      addr_reg, addr_next;
    logic [DATA_W-1:0]      wdata_reg, wdata_next;
    logic [OFF_W-1:0]       off_reg, off_next;
    logic [FAULT_W-1:0]     fault_reg, fault_next;

    logic [DATA_W-1:0]      fetch_cnt_reg, fetch_cnt_next;
    logic [DATA_W-1:0]      load_cnt_reg, load_cnt_next;
    logic [DATA_W-1:0]      store_cnt_reg, store_cnt_next;

    logic                   m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]      m_rdata_reg, m_rdata_next;
    logic [FAULT_W-1:0]     m_fault_reg, m_fault_next;
    logic [DATA_W-1:0]      m_fetch_reg, m_fetch_next;
    logic [DATA_W-1:0]      m_load_reg, m_load_next;
    logic [DATA_W-1:0]      m_store_reg, m_store_next;

    // Access decode on the captured word.
    logic                   act_known;
    logic                   act_word;
    logic                   act_write;
    logic                   access_ok;
    logic [DATA_W:0]        diff;
    logic [DATA_W-1:0]      limit;
    logic [FAULT_W-1:0]     fault_calc;

    // Bank ports.
    logic [1:0]             lane0;
    logic [ROW_W-1:0]       row0;
    logic [NUM_BANKS-1:0]   bank_en;
    logic [NUM_BANKS-1:0]   bank_we;
    logic [ROW_W-1:0]       bank_row   [NUM_BANKS];
    byte_t                  bank_wdata [NUM_BANKS];
    byte_t                  bank_rdata [NUM_BANKS];
    logic [DATA_W-1:0]      word_rd;
    logic                   out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    assign act_known = (act_reg <= ACT_WR32);
    assign act_word  = (act_reg == ACT_FETCH) || (act_reg == ACT_RD32) || (act_reg == ACT_WR32);
    assign act_write = (act_reg == ACT_WR8) || (act_reg == ACT_WR32);
    assign access_ok = act_known && (fault_reg == FAULT_NONE);

    // Offset from the base; the borrow bit flags an address below the base. The
    // bounds check compares against the last legal start offset for this width, so
    // only one subtract sits in front of the compare.
    assign diff  = {1'b0, addr_reg} - {1'b0, base_reg};
    assign limit = act_word ? LIMIT_WORD : LIMIT_BYTE;

    always_comb begin
        priority if (!act_known) begin
            fault_calc = FAULT_NONE;
        end else if (diff[DATA_W]) begin
            fault_calc = FAULT_BELOW;
        end else if (diff[DATA_W-1:0] > limit) begin
            fault_calc = FAULT_TOP;
        end else begin
            fault_calc = FAULT_NONE;
        end
    end

    assign lane0 = off_reg[1:0];
    assign row0  = off_reg[OFF_W-1:2];

    // Byte k of a word lands in bank (lane0 + k) % 4; banks below lane0 hold the
    // bytes that wrapped into the next row.
    always_comb begin
        logic [1:0] k;
        for (int j = 0; j < NUM_BANKS; j++) begin
            k = 2'(j) - lane0;
            if (state_reg == ST_CLEAR) begin
                bank_en[j]    = 1'b1;
                bank_we[j]    = 1'b1;
                bank_row[j]   = clr_row_reg;
                bank_wdata[j] = '0;
            end else begin
                bank_en[j]    = (state_reg == ST_ACCESS) && access_ok
                                && (act_word || (2'(j) == lane0));
                bank_we[j]    = act_write;
                bank_row[j]   = row0 + ROW_W'(2'(j) < lane0);
                bank_wdata[j] = wdata_reg[{k, 3'b000} +: BYTE_W];
            end
        end
    end

    for (genvar j = 0; j < NUM_BANKS; j++) begin : g_bank
        byte_t mem [BANK_DEPTH];

        always_ff @(posedge aclk) begin
            if (bank_en[j]) begin
                if (bank_we[j]) begin
                    mem[bank_row[j]] <= bank_wdata[j];
                end else begin
                    bank_rdata[j] <= mem[bank_row[j]];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            word_rd[BYTE_W*k +: BYTE_W] = bank_rdata[2'(k) + lane0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        base_next      = base_reg;
        act_next       = act_reg;
        addr_next      = addr_reg;
        wdata_next     = wdata_reg;
        off_next       = off_reg;
        fault_next     = fault_reg;
        fetch_cnt_next = fetch_cnt_reg;
        load_cnt_next  = load_cnt_reg;
        store_cnt_next = store_cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_rdata_next   = m_rdata_reg;
        m_fault_next   = m_fault_reg;
        m_fetch_next   = m_fetch_reg;
        m_load_next    = m_load_reg;
        m_store_next   = m_store_reg;

        if (cfg_valid && cfg_ready) begin
            base_next = cfg_base_address;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action;
                    addr_next  = s_address;
                    wdata_next = s_write_data;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                fault_next = fault_calc;
                off_next   = diff[OFF_W-1:0];
                state_next = ST_ACCESS;
            end
            ST_ACCESS: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    if (access_ok) begin
                        unique case (act_reg)
                            ACT_FETCH: fetch_cnt_next = fetch_cnt_reg + 1'b1;
                            ACT_RD8,
                            ACT_RD32:  load_cnt_next  = load_cnt_reg + 1'b1;
                            default:   store_cnt_next = store_cnt_reg + 1'b1;
                        endcase
                    end
                    priority if (!access_ok || act_write) begin
                        m_rdata_next = '0;
                    end else if (act_word) begin
                        m_rdata_next = word_rd;
                    end else begin
                        m_rdata_next = {{(DATA_W-BYTE_W){1'b0}}, bank_rdata[lane0]};
                    end
                    m_valid_next = 1'b1;
                    m_fault_next = act_known ? fault_reg : FAULT_NONE;
                    m_fetch_next = fetch_cnt_next;
                    m_load_next  = load_cnt_next;
                    m_store_next = store_cnt_next;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            base_reg      <= '0;
            fetch_cnt_reg <= '0;
            load_cnt_reg  <= '0;
            store_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            base_reg      <= base_next;
            fetch_cnt_reg <= fetch_cnt_next;
            load_cnt_reg  <= load_cnt_next;
            store_cnt_reg <= store_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
        act_reg     <= act_next;
        addr_reg    <= addr_next;
        wdata_reg   <= wdata_next;
        off_reg     <= off_next;
        fault_reg   <= fault_next;
        m_rdata_reg <= m_rdata_next;
        m_fault_reg <= m_fault_next;
        m_fetch_reg <= m_fetch_next;
        m_load_reg  <= m_load_next;
        m_store_reg <= m_store_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = m_rdata_reg;
    assign m_fault_code  = m_fault_reg;
    assign m_fetch_count = m_fetch_reg;
    assign m_load_count  = m_load_reg;
    assign m_store_count = m_store_reg;

endmodule

// ----- rtl/core/cbm_checker.sv -----
// Port-level checks for the checked byte memory, bound to its top level.
module cbm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [cbm_pkg::DATA_W-1:0]      m_read_data,
    input logic [cbm_pkg::FAULT_W-1:0]     m_fault_code,
    input logic [cbm_pkg::DATA_W-1:0]      m_fetch_count,
    input logic [cbm_pkg::DATA_W-1:0]      m_load_count,
    input logic [cbm_pkg::DATA_W-1:0]      m_store_count
);
    import cbm_pkg::*;

    // The clearing sweep keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during the clearing sweep");

    // Only one word is in flight, so acceptance closes the input.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while one is in flight");

    // A faulting access returns no data.
    a_fault_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_fault_code != FAULT_NONE) |-> (m_read_data == '0))
        else $error("faulting access returned data");

    // A stalled result keeps its counter values.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fetch_count)
            && $stable(m_load_count) && $stable(m_store_count))
        else $error("stalled result changed");

endmodule

bind checked_byte_memory_with_counters_top cbm_checker u_cbm_checker (.*);
